[hw/rtl/ile_pkg.sv]
// Shared constants for the indexed list engine: operation and status codes, default sizes.
package ile_pkg;

	localparam int DEF_CAPACITY  = 64;
	localparam int DEF_ITEM_BITS = 32;

	localparam int OP_W    = 3;
	localparam int POS_W   = 7;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 7;

	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
	localparam logic [OP_W-1:0] OP_ORDERED = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ    = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

endpackage

[hw/rtl/ile_mem.sv]
// Entry storage: one write port, one read port with registered read data.
module ile_mem import ile_pkg::*; #(
	parameter int DEPTH = DEF_CAPACITY,
	parameter int WIDTH = DEF_ITEM_BITS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/indexed_list_engine_core.sv]
// Top level of the indexed list engine: request sequencer, compare unit and result register.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, op, position,         | to block
//          | item_value                                |
//  out     | out_valid, out_ready, status, read_value, | from block
//          | entry_count                               |
//  cfg     | cfg_we, cfg_wdata (compare_mode)          | to block
//
// The entry memory has one read and one write port; every moved entry is read, then
// written, and every compared entry is read, then compared. Insert shifts the later
// entries up one place and remove shifts them down; ordered insert first searches from
// index 0 for the first stored entry that orders after the value, then shifts up.
// One request is worked at a time; in_ready is low meanwhile.
// The finished word waits in the output register, so the next request is taken while it
// is stalled; a second result waits until the first is taken. Reset empties the list.
module indexed_list_engine_core import ile_pkg::*; #(
	parameter int CAPACITY  = DEF_CAPACITY,
	parameter int ITEM_BITS = DEF_ITEM_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    op,
	input  logic [POS_W-1:0]   position,
	input  logic [VAL_W-1:0]   item_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STAT_W-1:0]  status,
	output logic [VAL_W-1:0]   read_value,
	output logic [COUNT_W-1:0] entry_count,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SRCH_RD  = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_SHU_RD   = 4'd3;
	localparam logic [3:0] S_SHU_WR   = 4'd4;
	localparam logic [3:0] S_SHD_RD   = 4'd5;
	localparam logic [3:0] S_SHD_WR   = 4'd6;
	localparam logic [3:0] S_RD_WAIT  = 4'd7;
	localparam logic [3:0] S_FIN      = 4'd8;

	logic [3:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     tgt_q;
	logic [ITEM_BITS-1:0] val_q;
	logic [STAT_W-1:0]    stat_q;
	logic [ITEM_BITS-1:0] rdv_q;
	logic                 cmp_mode_q;

	logic                 out_vld_q;
	logic [STAT_W-1:0]    out_stat_q;
	logic [VAL_W-1:0]     out_rdv_q;
	logic [COUNT_W-1:0]   out_cnt_q;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [ITEM_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]     mem_raddr;
	logic [ITEM_BITS-1:0] mem_rdata;

	logic [CNT_W-1:0]     idx_dn;
	logic [CNT_W-1:0]     idx_up;
	logic [CMP_W-1:0]     pos_x;
	logic [CMP_W-1:0]     cnt_x;
	logic                 pos_in;
	logic                 full;
	logic [63:0]          in_wide;
	logic [ITEM_BITS-1:0] in_val;
	logic [63:0]          rdv_wide;
	logic [ITEM_BITS-1:0] sgn;
	logic                 greater;
	logic                 out_free;

	ile_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (ITEM_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign idx_dn   = idx_q - CNT_W'(1);
	assign idx_up   = idx_q + CNT_W'(1);
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(cnt_q);
	assign pos_in   = pos_x < cnt_x;
	assign full     = cnt_q == CNT_W'(CAPACITY);
	assign in_wide  = 64'(item_value);
	assign in_val   = in_wide[ITEM_BITS-1:0];
	assign rdv_wide = 64'(rdv_q);

	// compare: stored entry orders strictly after the new value
	assign sgn     = ITEM_BITS'(cmp_mode_q) << (ITEM_BITS - 1);
	assign greater = (mem_rdata ^ sgn) > (val_q ^ sgn);

	assign out_free = !out_vld_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[IDX_W-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				// fetch the addressed entry while the request is offered
				mem_raddr = pos_x[IDX_W-1:0];
			end
			S_SHU_RD: begin
				if (idx_q == tgt_q) begin
					mem_we    = 1'b1;
					mem_wdata = val_q;
				end else begin
					mem_raddr = idx_dn[IDX_W-1:0];
				end
			end
			S_SHU_WR: begin
				mem_we = 1'b1;
			end
			S_SHD_RD: begin
				mem_raddr = idx_up[IDX_W-1:0];
			end
			S_SHD_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			idx_q      <= '0;
			tgt_q      <= '0;
			val_q      <= '0;
			stat_q     <= ST_DONE;
			rdv_q      <= '0;
			cmp_mode_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cmp_mode_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rdv_q <= '0;
						val_q <= in_val;
						unique case (op)
							OP_APPEND, OP_INSERT, OP_ORDERED: begin
								if (full) begin
									stat_q  <= ST_FULL;
									state_q <= S_FIN;
								end else if (op == OP_ORDERED) begin
									stat_q  <= ST_DONE;
									idx_q   <= '0;
									state_q <= S_SRCH_RD;
								end else begin
									stat_q  <= ST_DONE;
									idx_q   <= cnt_q;
									tgt_q   <= (op == OP_INSERT && pos_in) ?
									           CNT_W'(position) : cnt_q;
									state_q <= S_SHU_RD;
								end
							end
							OP_REMOVE: begin
								if (!pos_in) begin
									stat_q  <= ST_RANGE;
									state_q <= S_FIN;
								end else begin
									stat_q  <= ST_DONE;
									cnt_q   <= cnt_q - CNT_W'(1);
									idx_q   <= CNT_W'(position);
									state_q <= S_SHD_RD;
								end
							end
							OP_READ: begin
								if (!pos_in) begin
									stat_q  <= ST_RANGE;
									state_q <= S_FIN;
								end else begin
									stat_q  <= ST_DONE;
									idx_q   <= CNT_W'(position);
									state_q <= S_RD_WAIT;
								end
							end
							OP_CLEAR: begin
								stat_q  <= ST_DONE;
								cnt_q   <= '0;
								state_q <= S_FIN;
							end
							default: begin
								stat_q  <= ST_DONE;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					// capture the entry addressed while idle
					rdv_q   <= mem_rdata;
					state_q <= S_FIN;
				end
				S_SRCH_RD: begin
					if (idx_q == cnt_q) begin
						tgt_q   <= cnt_q;
						state_q <= S_SHU_RD;
					end else begin
						state_q <= S_SRCH_CMP;
					end
				end
				S_SRCH_CMP: begin
					if (greater) begin
						tgt_q   <= idx_q;
						idx_q   <= cnt_q;
						state_q <= S_SHU_RD;
					end else begin
						idx_q   <= idx_up;
						state_q <= S_SRCH_RD;
					end
				end
				S_SHU_RD: begin
					if (idx_q == tgt_q) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_FIN;
					end else begin
						state_q <= S_SHU_WR;
					end
				end
				S_SHU_WR: begin
					idx_q   <= idx_dn;
					state_q <= S_SHU_RD;
				end
				S_SHD_RD: begin
					state_q <= (idx_q == cnt_q) ? S_FIN : S_SHD_WR;
				end
				S_SHD_WR: begin
					idx_q   <= idx_up;
					state_q <= S_SHD_RD;
				end
				S_FIN: begin
					// hold until the output register frees up
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_stat_q <= stat_q;
			out_rdv_q  <= rdv_wide[VAL_W-1:0];
			out_cnt_q  <= COUNT_W'(cnt_q);
		end
	end

	assign out_valid   = out_vld_q;
	assign status      = out_stat_q;
	assign read_value  = out_rdv_q;
	assign entry_count = out_cnt_q;

endmodule
